// ----- rtl/ssfs_pkg.sv -----
// ----------------------------------------------------------------------------
// ssfs_pkg
// Shared constants, types and lookup functions for the frame serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssfs_pkg;

    localparam int FRAME_BITS = 24;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int VALUE_W    = 14;
    localparam int POS_W      = 2;
    localparam int OFF_W      = 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;
    localparam logic [OFF_W-1:0]   OFF_MAX   = 4'd8;
    localparam logic [3:0]         DIGIT_MAX = 4'd9;

    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef struct packed {
        logic load;
    } shift_ctrl_t;

    typedef struct packed {
        logic can_load;
    } shift_stat_t;

    // value divided by 10**k, exact for values up to 9999
    function automatic logic [VALUE_W-1:0] div_pow10(input logic [VALUE_W-1:0] v,
                                                     input logic [2:0] k);
        logic [29:0] prod10;
        logic [29:0] prod100;
        logic [29:0] prod1000;
        logic [VALUE_W-1:0] q;
        prod10   = 30'(v) * 30'd52429;
        prod100  = 30'(v) * 30'd5243;
        prod1000 = 30'(v) * 30'd16778;
        case (k)
            3'd0:    q = v;
            3'd1:    q = VALUE_W'(prod10 >> 19);
            3'd2:    q = VALUE_W'(prod100 >> 19);
            3'd3:    q = VALUE_W'(prod1000 >> 24);
            default: q = '0;
        endcase
        return q;
    endfunction

    function automatic logic [7:0] pos_select(input logic [POS_W-1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0: b = 8'hF7;
            2'd1: b = 8'hFB;
            2'd2: b = 8'hFD;
            2'd3: b = 8'hFE;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] b;
        unique case (d)
            4'd0:    b = 8'h3F;
            4'd1:    b = 8'h06;
            4'd2:    b = 8'h5B;
            4'd3:    b = 8'h4F;
            4'd4:    b = 8'h66;
            4'd5:    b = 8'h6D;
            4'd6:    b = 8'h7D;
            4'd7:    b = 8'h07;
            4'd8:    b = 8'h7F;
            default: b = 8'h67;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/seven_segment_frame_serializer.sv -----
// ----------------------------------------------------------------------------
// seven_segment_frame_serializer
// Display frame serializer: one command in, 24 serial beats out.
// ----------------------------------------------------------------------------
// start stores a command in the input register; it then loads the shift register,
// and the first beat strobes after that load; with a command held, frames leave
// with no gap between them; the 24-bit shift register and bit counter pace them
// a held command waits in the input register; busy is high while it waits
// rst_n clears the valid flag and bit counter; data registers are not reset
`default_nettype none

module seven_segment_frame_serializer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic [ssfs_pkg::VALUE_W-1:0] value,
    input  wire logic [ssfs_pkg::POS_W-1:0]   digit_pos,
    input  wire logic [ssfs_pkg::OFF_W-1:0]   leds_off,
    output      logic                         strobe,
    output      logic                         serial_bit,
    output      logic                         latch_after
);
    import ssfs_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [OFF_W-1:0]   off_reg;
    logic               accept;
    frame_t             frame;
    shift_ctrl_t        ctrl;
    shift_stat_t        stat;

    assign ctrl.load = in_valid_reg && stat.can_load;
    assign busy      = in_valid_reg && !ctrl.load;
    assign accept    = start && !busy;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (ctrl.load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value;
            pos_reg   <= digit_pos;
            off_reg   <= leds_off;
        end
    end

    ssfs_frame u_frame (
        .value     (value_reg),
        .digit_pos (pos_reg),
        .leds_off  (off_reg),
        .frame     (frame)
    );

    ssfs_shift u_shift (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame),
        .ctrl        (ctrl),
        .stat        (stat),
        .strobe      (strobe),
        .serial_bit  (serial_bit),
        .latch_after (latch_after)
    );

    a_busy_held: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_valid_reg)
        else $error("busy without a held command");

    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_valid_reg)
        else $error("accepted command lost");

endmodule

`default_nettype wire

// ----- rtl/ssfs_frame.sv -----
// ----------------------------------------------------------------------------
// ssfs_frame
// Builds the 24-bit frame: position select, segment pattern, bargraph byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfs_frame (
    input  wire logic [ssfs_pkg::VALUE_W-1:0] value,
    input  wire logic [ssfs_pkg::POS_W-1:0]   digit_pos,
    input  wire logic [ssfs_pkg::OFF_W-1:0]   leds_off,
    output      ssfs_pkg::frame_t             frame
);
    import ssfs_pkg::*;

    logic [VALUE_W-1:0] value_sat;
    logic [OFF_W-1:0]   off_sat;
    logic [2:0]         k_lo;
    logic [2:0]         k_hi;
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] q10;
    logic [VALUE_W-1:0] digit_wide;
    logic [3:0]         digit;
    logic [15:0]        bar_wide;

    always_comb
    begin
        value_sat  = (value > VALUE_MAX) ? VALUE_MAX : value;
        off_sat    = (leds_off > OFF_MAX) ? OFF_MAX : leds_off;
        k_lo       = {1'b0, digit_pos};
        k_hi       = k_lo + 3'd1;
        q          = div_pow10(value_sat, k_lo);
        q10        = div_pow10(value_sat, k_hi);
        digit_wide = q - (q10 << 3) - (q10 << 1);
        digit      = (digit_wide > VALUE_W'(DIGIT_MAX)) ? DIGIT_MAX : digit_wide[3:0];
        bar_wide   = 16'h00FF << off_sat;
        frame      = {pos_select(digit_pos), seg_pattern(digit), bar_wide[7:0]};
    end

endmodule

`default_nettype wire

// ----- rtl/ssfs_shift.sv -----
// ----------------------------------------------------------------------------
// ssfs_shift
// Frame shift register, msb first, with bit counter and last-bit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfs_shift (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ssfs_pkg::frame_t      frame,
    input  wire ssfs_pkg::shift_ctrl_t ctrl,
    output      ssfs_pkg::shift_stat_t stat,
    output      logic                  strobe,
    output      logic                  serial_bit,
    output      logic                  latch_after
);
    import ssfs_pkg::*;

    frame_t shift_reg;
    frame_t shift_next;
    cnt_t   cnt_reg;
    cnt_t   cnt_next;

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (ctrl.load)
        begin
            shift_next = frame;
            cnt_next   = CNT_W'(FRAME_BITS);
        end
        else if (cnt_reg != '0)
        begin
            shift_next = {shift_reg[FRAME_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    // free again once the last bit is on the line
    assign stat.can_load = (cnt_reg <= cnt_t'(1));
    assign strobe        = (cnt_reg != '0);
    assign serial_bit    = shift_reg[FRAME_BITS-1];
    assign latch_after   = (cnt_reg == cnt_t'(1));

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FRAME_BITS))
        else $error("bit counter out of range");

    a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (cnt_reg == CNT_W'(FRAME_BITS)))
        else $error("frame load did not arm counter");

    a_load_gap: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> (cnt_reg <= cnt_t'(1)))
        else $error("frame loaded over an unfinished frame");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !latch_after) |=> strobe)
        else $error("frame beats interrupted");

endmodule

`default_nettype wire
